/* rtl/core/backlight_dimming_ramp_top_macros.svh */
// Assertion macros shared by the backlight dimming ramp RTL.
`ifndef BACKLIGHT_DIMMING_RAMP_TOP_MACROS_SVH
`define BACKLIGHT_DIMMING_RAMP_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BDR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("backlight dimming ramp assertion failed");
`define BDR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("backlight dimming ramp assertion failed");
`else
`define BDR_ASSERT_IMP(name, ante, cons)
`define BDR_ASSERT_NXT(name, ante, cons)
`endif

`endif

/* rtl/core/bdr_pkg.sv */
// Types, constants and helper functions of the backlight dimming ramp.
`timescale 1ns / 1ps
package bdr_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_TOUCH = 2'd1,
    OP_START = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    REG_NORMAL_PCT  = 3'd0,
    REG_REDUCED_PCT = 3'd1,
    REG_IDLE_TENS   = 3'd2,
    REG_NIGHT_START = 3'd3,
    REG_NIGHT_END   = 3'd4,
    REG_NIGHT_EN    = 3'd5,
    REG_IDLE_EN     = 3'd6
  } reg_idx_e;

  localparam logic [7:0]  STEP_MAX         = 8'd8;
  localparam logic [7:0]  DUTY_FULL        = 8'd255;
  localparam logic [6:0]  PCT_FULL         = 7'd100;
  localparam logic [31:0] UPDATE_PERIOD_MS = 32'd16;
  localparam logic [21:0] MS_PER_TEN_S     = 22'd10000;
  // Scale factor: pct * 255 / 100 equals (pct * 1336965) >> 19 for pct below 100.
  localparam logic [27:0] PCT_SCALE        = 28'd1336965;

  localparam logic [6:0]  NORMAL_PCT_RST   = 7'd100;
  localparam logic [6:0]  REDUCED_PCT_RST  = 7'd20;
  localparam logic [7:0]  IDLE_TENS_RST    = 8'd6;
  localparam logic [4:0]  NIGHT_START_RST  = 5'd22;
  localparam logic [4:0]  NIGHT_END_RST    = 5'd6;

  function automatic logic [7:0] pct_to_duty(input logic [6:0] pct);
    logic [27:0] prod;
    prod = 28'(pct) * PCT_SCALE;
    if (pct >= PCT_FULL) begin
      return DUTY_FULL;
    end
    return prod[26:19];
  endfunction

  function automatic logic [21:0] idle_limit(input logic [7:0] tens);
    return 22'(tens) * MS_PER_TEN_S;
  endfunction

endpackage

/* rtl/core/backlight_dimming_ramp_top.sv */
// Backlight dimming ramp: request handling, duty ramp and configuration registers.
// Input requests carry an operation (tick, touch or start), a millisecond
// timestamp and the local hour; each request yields exactly one result that
// holds the duty after the request and a flag telling whether it changed.
// Both channels use valid and stall; a request moves when valid is high and
// stall is low. A request is first captured in an input register; once the
// result register can advance, the duty logic runs and writes the state and
// the result register, from which the result is offered.
// One request per cycle is sustained while the receiver does not stall; the
// only loop is the duty and timestamp state, updated in the same cycle as the result.
// While the receiver stalls, the result register holds and the input register
// still takes one more request, after which in_stall_o rises.
// Reset zeroes the duty and both timestamps and loads the register defaults.
// Registers are written through the APB-style port at byte address 4*index; the
// user must write them only while no request is in flight, which the block does
// not enforce. Scaled duty levels and the idle limit update at their register's edge.
`timescale 1ns / 1ps
module backlight_dimming_ramp_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] now_ms_i,
  input  logic [4:0]  hour_of_day_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  duty_o,
  output logic        duty_changed_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bdr_pkg::*;

  `include "backlight_dimming_ramp_top_macros.svh"

  logic [6:0]  normal_pct_q;
  logic [6:0]  reduced_pct_q;
  logic [7:0]  idle_tens_q;
  logic [4:0]  night_start_q;
  logic [4:0]  night_end_q;
  logic        night_en_q;
  logic        idle_en_q;

  logic [7:0]  normal_duty_q;
  logic [7:0]  reduced_duty_q;
  logic [21:0] idle_limit_q;

  logic        in_valid_q;
  op_e         op_q;
  logic [31:0] now_q;
  logic [4:0]  hour_q;

  logic        out_valid_q;
  logic [7:0]  duty_q;
  logic        duty_changed_q;

  logic [7:0]  cur_duty_q;
  logic [7:0]  cur_duty_d;
  logic [31:0] last_touch_q;
  logic [31:0] last_touch_d;
  logic [31:0] last_update_q;
  logic [31:0] last_update_d;

  logic        cfg_wr;
  reg_idx_e    cfg_idx;
  logic        out_adv;
  logic        proc;
  logic        in_acc;
  logic        tick_due;
  logic        in_night;
  logic        idle_out;
  logic        dim;
  logic [31:0] since_update;
  logic [31:0] since_touch;
  logic [7:0]  target;
  logic [7:0]  ramped;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_NORMAL_PCT:  prdata = 32'(normal_pct_q);
      REG_REDUCED_PCT: prdata = 32'(reduced_pct_q);
      REG_IDLE_TENS:   prdata = 32'(idle_tens_q);
      REG_NIGHT_START: prdata = 32'(night_start_q);
      REG_NIGHT_END:   prdata = 32'(night_end_q);
      REG_NIGHT_EN:    prdata = 32'(night_en_q);
      REG_IDLE_EN:     prdata = 32'(idle_en_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_pct_q   <= NORMAL_PCT_RST;
      reduced_pct_q  <= REDUCED_PCT_RST;
      idle_tens_q    <= IDLE_TENS_RST;
      night_start_q  <= NIGHT_START_RST;
      night_end_q    <= NIGHT_END_RST;
      night_en_q     <= 1'b0;
      idle_en_q      <= 1'b0;
      normal_duty_q  <= pct_to_duty(NORMAL_PCT_RST);
      reduced_duty_q <= pct_to_duty(REDUCED_PCT_RST);
      idle_limit_q   <= idle_limit(IDLE_TENS_RST);
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_NORMAL_PCT: begin
            normal_pct_q  <= pwdata[6:0];
            normal_duty_q <= pct_to_duty(pwdata[6:0]);
          end
          REG_REDUCED_PCT: begin
            reduced_pct_q  <= pwdata[6:0];
            reduced_duty_q <= pct_to_duty(pwdata[6:0]);
          end
          REG_IDLE_TENS: begin
            idle_tens_q  <= pwdata[7:0];
            idle_limit_q <= idle_limit(pwdata[7:0]);
          end
          REG_NIGHT_START: night_start_q <= pwdata[4:0];
          REG_NIGHT_END:   night_end_q   <= pwdata[4:0];
          REG_NIGHT_EN:    night_en_q    <= pwdata[0];
          REG_IDLE_EN:     idle_en_q     <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_adv;
  assign in_stall_o = in_valid_q && !out_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign since_update = now_q - last_update_q;
  assign since_touch  = now_q - last_touch_q;
  assign tick_due     = since_update >= UPDATE_PERIOD_MS;

  always_comb begin
    if (night_start_q == night_end_q) begin
      in_night = 1'b0;
    end else if (night_start_q < night_end_q) begin
      in_night = (hour_q >= night_start_q) && (hour_q < night_end_q);
    end else begin
      in_night = (hour_q >= night_start_q) || (hour_q < night_end_q);
    end
  end

  assign idle_out = since_touch >= 32'(idle_limit_q);
  assign dim      = (night_en_q && in_night) || (idle_en_q && idle_out);
  assign target   = dim ? reduced_duty_q : normal_duty_q;

  always_comb begin
    if (target > cur_duty_q) begin
      ramped = ((target - cur_duty_q) > STEP_MAX) ? cur_duty_q + STEP_MAX : target;
    end else if (cur_duty_q > target) begin
      ramped = ((cur_duty_q - target) > STEP_MAX) ? cur_duty_q - STEP_MAX : target;
    end else begin
      ramped = cur_duty_q;
    end
  end

  always_comb begin
    cur_duty_d    = cur_duty_q;
    last_touch_d  = last_touch_q;
    last_update_d = last_update_q;
    unique case (op_q)
      OP_TICK: begin
        if (tick_due) begin
          cur_duty_d    = ramped;
          last_update_d = now_q;
        end
      end
      OP_TOUCH: begin
        last_touch_d = now_q;
      end
      OP_START: begin
        cur_duty_d   = normal_duty_q;
        last_touch_d = now_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      cur_duty_q    <= '0;
      last_touch_q  <= '0;
      last_update_q <= '0;
    end else begin
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc) begin
        out_valid_q   <= 1'b1;
        cur_duty_q    <= cur_duty_d;
        last_touch_q  <= last_touch_d;
        last_update_q <= last_update_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_e'(operation_i);
      now_q  <= now_ms_i;
      hour_q <= hour_of_day_i;
    end
    if (proc) begin
      duty_q         <= cur_duty_d;
      duty_changed_q <= cur_duty_d != cur_duty_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign duty_o         = duty_q;
  assign duty_changed_o = duty_changed_q;

  `BDR_ASSERT_NXT(a_proc_gives_result, proc, out_valid_o)
  `BDR_ASSERT_NXT(a_changed_flag, proc, duty_changed_o == (duty_o != $past(cur_duty_q)))
  `BDR_ASSERT_NXT(a_early_tick_holds, proc && (op_q == OP_TICK) && !tick_due, !duty_changed_o)
  `BDR_ASSERT_IMP(a_stall_needs_item, in_stall_o, in_valid_q && out_valid_q)

endmodule
